// File: design/bol_pkg.sv
`timescale 1ns / 1ps

package bol_pkg;

  // list geometry
  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 16;
  localparam int ITEM_W      = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int COUNT_W     = $clog2(CAPACITY + 1);
  localparam int OP_W        = 4;
  localparam int POS_W       = 6;
  localparam int STATUS_W    = 2;
  localparam int OUT_COUNT_W = 7;

  typedef logic [HANDLE_BITS-1:0] handle_t;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND    = 4'd0;
  localparam logic [OP_W-1:0] OP_PREPEND   = 4'd1;
  localparam logic [OP_W-1:0] OP_RM_VALUE  = 4'd2;
  localparam logic [OP_W-1:0] OP_RM_AT     = 4'd3;
  localparam logic [OP_W-1:0] OP_RM_FIRST  = 4'd4;
  localparam logic [OP_W-1:0] OP_RM_LAST   = 4'd5;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd6;
  localparam logic [OP_W-1:0] OP_GET       = 4'd7;
  localparam logic [OP_W-1:0] OP_INCLUDES  = 4'd8;
  localparam logic [OP_W-1:0] OP_POP       = 4'd9;
  localparam logic [OP_W-1:0] OP_PEEK_LAST = 4'd10;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

  // what a cell does at the next edge
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_TAKE_LOWER,
    ACT_TAKE_UPPER
  } cell_act_e;

endpackage

// File: design/bol_cell.sv
`timescale 1ns / 1ps

module bol_cell (
  input  logic               clk_i,
  input  bol_pkg::cell_act_e act_i,
  input  bol_pkg::handle_t   load_i,
  input  bol_pkg::handle_t   lower_i,
  input  bol_pkg::handle_t   upper_i,
  input  bol_pkg::handle_t   cmp_i,
  output bol_pkg::handle_t   data_o,
  output logic               match_o
);
  import bol_pkg::*;

  handle_t data_q;

  // entry register: hold, load, or take a neighbor's entry
  always_ff @(posedge clk_i) begin
    unique case (act_i)
      ACT_HOLD:       data_q <= data_q;
      ACT_LOAD:       data_q <= load_i;
      ACT_TAKE_LOWER: data_q <= lower_i;
      ACT_TAKE_UPPER: data_q <= upper_i;
      default:        data_q <= data_q;
    endcase
  end

  assign data_o  = data_q;
  assign match_o = (data_q == cmp_i);

endmodule

// File: design/bounded_ordered_list.sv
`timescale 1ns / 1ps

// Ordered list of 64 handles held in a row of cells, one entry per cell; a
// cell can load the request's handle or take the entry of either neighbor,
// so inserts at the front and removals by position or from the front shift
// every affected entry at once. A request is taken at an edge with start
// high and busy low. Most operations execute at the next edge and the result
// strobe done_o then goes high for a single cycle; the next request may be
// issued in the cycle the result is shown. Remove value closes one gap
// per cycle in the cell row.
// The receiver cannot stall: each result is valid only while done_o is high.
// Entries are not reset; only the fill count is cleared, so no clearing pass.
module bounded_ordered_list (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [bol_pkg::OP_W-1:0]         operation_i,
  input  logic [bol_pkg::ITEM_W-1:0]       item_i,
  input  logic [bol_pkg::POS_W-1:0]        position_i,
  output logic                             done_o,
  output logic [bol_pkg::ITEM_W-1:0]       item_out_o,
  output logic                             found_o,
  output logic [bol_pkg::OUT_COUNT_W-1:0]  entry_count_o,
  output logic [bol_pkg::STATUS_W-1:0]     status_o
);
  import bol_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [OP_W-1:0]     op_q;
  handle_t             item_q;
  logic [IDX_W-1:0]    pos_q;
  logic [COUNT_W-1:0]  count_q, count_d;
  handle_t             item_out_q, item_out_d;
  logic                found_q, found_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                done_q, done_d;

  handle_t             cell_data [CAPACITY];
  cell_act_e           cell_act  [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] match_v;
  logic [CAPACITY-1:0] match_pre;

  logic                accept;
  logic                is_exec, empty, full, oob, any_match;
  logic                do_append, do_prepend, do_rm_at, do_rm_first, scan_hit;
  logic [IDX_W-1:0]    rd_idx;
  handle_t             rd_data;

  assign accept = start & ~busy;
  assign busy   = (state_q != ST_IDLE);

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      item_q <= item_i[HANDLE_BITS-1:0];
      pos_q  <= position_i[IDX_W-1:0];
    end
  end

  // list condition flags
  assign is_exec   = (state_q == ST_EXEC);
  assign empty     = (count_q == '0);
  assign full      = (count_q >= COUNT_W'(CAPACITY));
  assign oob       = (COUNT_W'(pos_q) >= count_q);
  assign any_match = |match_v;

  assign do_append   = is_exec & (op_q == OP_APPEND) & ~full;
  assign do_prepend  = is_exec & (op_q == OP_PREPEND) & ~full;
  assign do_rm_at    = is_exec & (op_q == OP_RM_AT) & ~empty & ~oob;
  assign do_rm_first = is_exec & (op_q == OP_RM_FIRST) & ~empty;
  assign scan_hit    = (state_q == ST_SCAN) & any_match;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    handle_t lower, upper;

    if (i == 0) begin : g_first
      assign lower = item_q;
    end else begin : g_lower
      assign lower = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_upper
      assign upper = cell_data[i+1];
    end

    // live match and first-match-at-or-below flag
    assign match_v[i]   = cell_match[i] & (COUNT_W'(i) < count_q);
    assign match_pre[i] = |match_v[i:0];

    // per-cell action
    always_comb begin
      priority if (do_prepend) begin
        cell_act[i] = (i == 0) ? ACT_LOAD : ACT_TAKE_LOWER;
      end else if (do_append && (COUNT_W'(i) == count_q)) begin
        cell_act[i] = ACT_LOAD;
      end else if (do_rm_at && (IDX_W'(i) >= pos_q)) begin
        cell_act[i] = ACT_TAKE_UPPER;
      end else if (do_rm_first) begin
        cell_act[i] = ACT_TAKE_UPPER;
      end else if (scan_hit && match_pre[i]) begin
        cell_act[i] = ACT_TAKE_UPPER;
      end else begin
        cell_act[i] = ACT_HOLD;
      end
    end

    bol_cell u_cell (
      .clk_i   (clk_i),
      .act_i   (cell_act[i]),
      .load_i  (item_q),
      .lower_i (lower),
      .upper_i (upper),
      .cmp_i   (item_q),
      .data_o  (cell_data[i]),
      .match_o (cell_match[i])
    );
  end

  // read port: get uses the position, pop and peek the last entry
  assign rd_idx  = (op_q == OP_GET) ? pos_q : IDX_W'(count_q - COUNT_W'(1));
  assign rd_data = cell_data[rd_idx];

  // control and result
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    item_out_d = item_out_q;
    found_d    = found_q;
    status_d   = status_q;
    done_d     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d    = ST_IDLE;
        done_d     = 1'b1;
        item_out_d = '0;
        found_d    = 1'b0;
        status_d   = STAT_OK;
        unique case (op_q)
          OP_APPEND, OP_PREPEND: begin
            if (full) status_d = STAT_FULL;
            else      count_d  = count_q + COUNT_W'(1);
          end
          OP_RM_VALUE: begin
            state_d = ST_SCAN;
            done_d  = 1'b0;
          end
          OP_RM_AT, OP_GET: begin
            if (empty) begin
              status_d = STAT_EMPTY;
            end else if (oob) begin
              status_d = STAT_RANGE;
            end else if (op_q == OP_RM_AT) begin
              count_d = count_q - COUNT_W'(1);
            end else begin
              item_out_d = rd_data;
            end
          end
          OP_RM_FIRST, OP_RM_LAST, OP_POP, OP_PEEK_LAST: begin
            if (empty) begin
              status_d = STAT_EMPTY;
            end else begin
              if (op_q == OP_POP || op_q == OP_PEEK_LAST) item_out_d = rd_data;
              if (op_q != OP_PEEK_LAST) count_d = count_q - COUNT_W'(1);
            end
          end
          OP_CLEAR:    count_d = '0;
          OP_INCLUDES: found_d = any_match;
          default: ;
        endcase
      end
      ST_SCAN: begin
        // one occurrence removed per cycle until none is left
        if (any_match) begin
          count_d = count_q - COUNT_W'(1);
          found_d = 1'b1;
        end else begin
          state_d    = ST_IDLE;
          done_d     = 1'b1;
          item_out_d = '0;
          status_d   = STAT_OK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    item_out_q <= item_out_d;
    found_q    <= found_d;
    status_q   <= status_d;
  end

  assign done_o        = done_q;
  assign item_out_o    = ITEM_W'(item_out_q);
  assign found_o       = found_q;
  assign entry_count_o = OUT_COUNT_W'(count_q);
  assign status_o      = status_q;

endmodule

// File: design/bol_checker.sv
`timescale 1ns / 1ps

module bol_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             done_o,
  input logic [bol_pkg::ITEM_W-1:0]       item_out_o,
  input logic [bol_pkg::OUT_COUNT_W-1:0]  entry_count_o,
  input logic [bol_pkg::STATUS_W-1:0]     status_o
);
  import bol_pkg::*;

  // a taken request keeps the block busy for its execution cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  // a result strobe follows a busy cycle, is shown while not busy, and falls right after
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy) ##1 !done_o)
    else $error("result strobe malformed");

  // a full rejection reports a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_FULL) |-> (entry_count_o == OUT_COUNT_W'(CAPACITY)))
    else $error("full status with list not full");

  // an empty rejection reports an empty list
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_EMPTY) |-> (entry_count_o == '0))
    else $error("empty status with entries present");

  // failed requests read nothing
  a_fail_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_OK) |-> (item_out_o == '0))
    else $error("handle returned with error status");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .item_out_o    (item_out_o),
  .entry_count_o (entry_count_o),
  .status_o      (status_o)
);
